// ===== rtl/core/tgc_pkg.sv =====
// Shared types and constants for the tilt gravity conditioner.
// Holds the register map, the microcode word layout and the datapath control types.
// No dependencies.
package tgc_pkg;

    // Configuration port geometry
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 15;

    // Sequencer geometry
    localparam int STEP_W = 4;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Arithmetic constants
    localparam logic [31:0]        MAG_LIMIT_SQ    = 32'd1638400;
    localparam logic [17:0]        INV_GRAVITY_Q16 = 18'd6683;
    localparam logic [17:0]        UNITY_COEF      = 18'd65536;
    localparam logic signed [16:0] ONE_Q14         = 17'sd16384;

    // Register reset values
    localparam logic [7:0]  RST_QUIET_ALPHA    = 8'd51;
    localparam logic [7:0]  RST_MOTION_ALPHA   = 8'd123;
    localparam logic [14:0] RST_FAST_STEP      = 15'd1229;
    localparam logic [9:0]  RST_INPUT_GAIN     = 10'd358;
    localparam logic [14:0] RST_CLAMP_LIMIT    = 15'd24576;
    localparam logic [11:0] RST_DEAD_ZONE      = 12'd246;
    localparam logic [11:0] RST_SNAP_BAND      = 12'd295;
    localparam logic [11:0] RST_OUT_HYSTERESIS = 12'd98;

    // Register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_QUIET_ALPHA    = 3'd0,
        REG_MOTION_ALPHA   = 3'd1,
        REG_FAST_STEP      = 3'd2,
        REG_INPUT_GAIN     = 3'd3,
        REG_CLAMP_LIMIT    = 3'd4,
        REG_DEAD_ZONE      = 3'd5,
        REG_SNAP_BAND      = 3'd6,
        REG_OUT_HYSTERESIS = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]  quiet_alpha;
        logic [7:0]  motion_alpha;
        logic [14:0] fast_step;
        logic [9:0]  input_gain;
        logic [14:0] clamp_limit;
        logic [11:0] dead_zone;
        logic [11:0] snap_band;
        logic [11:0] out_hysteresis;
    } cfg_t;

    // Multiplier operand A sources
    typedef enum logic [2:0] {
        A_AX,
        A_AY,
        A_NAY,
        A_AZ,
        A_SAVED,
        A_DELTA_X,
        A_DELTA_Y
    } a_sel_t;

    // Multiplier operand B sources
    typedef enum logic [2:0] {
        B_AX,
        B_AY,
        B_AZ,
        B_GAIN,
        B_COEF,
        B_ALPHA_X,
        B_ALPHA_Y
    } b_sel_t;

    // What a step does with the product of the previous step
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_ACC_LOAD,
        ACT_ACC_ADD,
        ACT_DIV_SET,
        ACT_SAVE,
        ACT_TGT_X,
        ACT_TGT_Y,
        ACT_FILT_X,
        ACT_FILT_Y
    } act_t;

    // Jump conditions
    typedef enum logic {
        COND_NONE,
        COND_FAIL
    } cond_t;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_EMIT = 4'd11;

    // One microcode word
    typedef struct packed {
        a_sel_t a_sel;
        b_sel_t b_sel;
        act_t   act;
        logic   hold_x;
        logic   hold_y;
        cond_t  cond;
        step_t  jmp;
        logic   emit;
    } ucode_t;

    // Sequencer to datapath control
    typedef struct packed {
        logic   load;
        logic   emit;
        a_sel_t a_sel;
        b_sel_t b_sel;
        act_t   act;
        logic   hold_x;
        logic   hold_y;
    } dp_ctrl_t;

    // Datapath to sequencer status
    typedef struct packed {
        logic read_failed;
    } dp_stat_t;

endpackage

// ===== rtl/core/tgc_cfg_regs.sv =====
// Configuration register bank of the tilt gravity conditioner.
// Decodes the plain write port into the register set.
// Depends on tgc_pkg.
module tgc_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tgc_pkg::CFG_ADDR_W-1:0]  cfg_index,
    input  logic [tgc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output tgc_pkg::cfg_t                   cfg
);

    tgc_pkg::cfg_t cfg_reg;
    tgc_pkg::cfg_t cfg_next;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (tgc_pkg::cfg_idx_t'(cfg_index))
                tgc_pkg::REG_QUIET_ALPHA:    cfg_next.quiet_alpha    = cfg_wdata[7:0];
                tgc_pkg::REG_MOTION_ALPHA:   cfg_next.motion_alpha   = cfg_wdata[7:0];
                tgc_pkg::REG_FAST_STEP:      cfg_next.fast_step      = cfg_wdata[14:0];
                tgc_pkg::REG_INPUT_GAIN:     cfg_next.input_gain     = cfg_wdata[9:0];
                tgc_pkg::REG_CLAMP_LIMIT:    cfg_next.clamp_limit    = cfg_wdata[14:0];
                tgc_pkg::REG_DEAD_ZONE:      cfg_next.dead_zone      = cfg_wdata[11:0];
                tgc_pkg::REG_SNAP_BAND:      cfg_next.snap_band      = cfg_wdata[11:0];
                tgc_pkg::REG_OUT_HYSTERESIS: cfg_next.out_hysteresis = cfg_wdata[11:0];
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quiet_alpha    <= tgc_pkg::RST_QUIET_ALPHA;
            cfg_reg.motion_alpha   <= tgc_pkg::RST_MOTION_ALPHA;
            cfg_reg.fast_step      <= tgc_pkg::RST_FAST_STEP;
            cfg_reg.input_gain     <= tgc_pkg::RST_INPUT_GAIN;
            cfg_reg.clamp_limit    <= tgc_pkg::RST_CLAMP_LIMIT;
            cfg_reg.dead_zone      <= tgc_pkg::RST_DEAD_ZONE;
            cfg_reg.snap_band      <= tgc_pkg::RST_SNAP_BAND;
            cfg_reg.out_hysteresis <= tgc_pkg::RST_OUT_HYSTERESIS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/tgc_sequencer.sv =====
// Microcode sequencer of the tilt gravity conditioner.
// Holds the control program, the step counter and the stream handshakes.
// Depends on tgc_pkg.
module tgc_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  tgc_pkg::dp_stat_t   stat,
    output tgc_pkg::dp_ctrl_t   ctrl
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } seq_state_t;

    seq_state_t      state_reg;
    seq_state_t      state_next;
    tgc_pkg::step_t  step_reg;
    tgc_pkg::step_t  step_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    tgc_pkg::ucode_t word;
    logic            accept;
    logic            emit_ok;
    logic            running;

    // Build one control word
    function automatic tgc_pkg::ucode_t uword(
        input tgc_pkg::a_sel_t a,
        input tgc_pkg::b_sel_t b,
        input tgc_pkg::act_t   act,
        input logic            hx,
        input logic            hy,
        input tgc_pkg::cond_t  cond,
        input logic            emit
    );
        tgc_pkg::ucode_t w;
        w.a_sel  = a;
        w.b_sel  = b;
        w.act    = act;
        w.hold_x = hx;
        w.hold_y = hy;
        w.cond   = cond;
        w.jmp    = tgc_pkg::STEP_EMIT;
        w.emit   = emit;
        return w;
    endfunction

    // Control program: each step multiplies once and consumes the previous product
    function automatic tgc_pkg::ucode_t ucode_rom(input tgc_pkg::step_t s);
        tgc_pkg::ucode_t w;
        unique case (s)
            4'd0:  w = uword(tgc_pkg::A_AX, tgc_pkg::B_AX, tgc_pkg::ACT_NONE,
                             1'b0, 1'b0, tgc_pkg::COND_FAIL, 1'b0);
            4'd1:  w = uword(tgc_pkg::A_AY, tgc_pkg::B_AY, tgc_pkg::ACT_ACC_LOAD,
                             1'b0, 1'b0, tgc_pkg::COND_NONE, 1'b0);
            4'd2:  w = uword(tgc_pkg::A_AZ, tgc_pkg::B_AZ, tgc_pkg::ACT_ACC_ADD,
                             1'b0, 1'b0, tgc_pkg::COND_NONE, 1'b0);
            4'd3:  w = uword(tgc_pkg::A_NAY, tgc_pkg::B_GAIN, tgc_pkg::ACT_DIV_SET,
                             1'b0, 1'b0, tgc_pkg::COND_NONE, 1'b0);
            4'd4:  w = uword(tgc_pkg::A_AX, tgc_pkg::B_GAIN, tgc_pkg::ACT_SAVE,
                             1'b0, 1'b0, tgc_pkg::COND_NONE, 1'b0);
            4'd5:  w = uword(tgc_pkg::A_SAVED, tgc_pkg::B_COEF, tgc_pkg::ACT_SAVE,
                             1'b0, 1'b0, tgc_pkg::COND_NONE, 1'b0);
            4'd6:  w = uword(tgc_pkg::A_SAVED, tgc_pkg::B_COEF, tgc_pkg::ACT_TGT_X,
                             1'b0, 1'b0, tgc_pkg::COND_NONE, 1'b0);
            4'd7:  w = uword(tgc_pkg::A_DELTA_X, tgc_pkg::B_ALPHA_X, tgc_pkg::ACT_TGT_Y,
                             1'b0, 1'b0, tgc_pkg::COND_NONE, 1'b0);
            4'd8:  w = uword(tgc_pkg::A_DELTA_Y, tgc_pkg::B_ALPHA_Y, tgc_pkg::ACT_FILT_X,
                             1'b0, 1'b0, tgc_pkg::COND_NONE, 1'b0);
            4'd9:  w = uword(tgc_pkg::A_AX, tgc_pkg::B_AX, tgc_pkg::ACT_FILT_Y,
                             1'b1, 1'b0, tgc_pkg::COND_NONE, 1'b0);
            4'd10: w = uword(tgc_pkg::A_AX, tgc_pkg::B_AX, tgc_pkg::ACT_NONE,
                             1'b0, 1'b1, tgc_pkg::COND_NONE, 1'b0);
            default: w = uword(tgc_pkg::A_AX, tgc_pkg::B_AX, tgc_pkg::ACT_NONE,
                               1'b0, 1'b0, tgc_pkg::COND_NONE, 1'b1);
        endcase
        return w;
    endfunction

    assign word     = ucode_rom(step_reg);
    assign running  = (state_reg == ST_RUN);
    assign accept   = in_valid && !running;
    assign emit_ok  = !out_valid_reg || out_ready;
    assign in_ready = !running;

    // Advance the step counter, take jumps, stall at emit while the output is full and not taken
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctrl.load      = accept;
        ctrl.emit      = 1'b0;
        ctrl.a_sel     = word.a_sel;
        ctrl.b_sel     = word.b_sel;
        ctrl.act       = tgc_pkg::ACT_NONE;
        ctrl.hold_x    = 1'b0;
        ctrl.hold_y    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                ctrl.act    = word.act;
                ctrl.hold_x = word.hold_x;
                ctrl.hold_y = word.hold_y;
                priority if (word.emit)
                begin
                    if (emit_ok)
                    begin
                        ctrl.emit      = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if (word.cond == tgc_pkg::COND_FAIL && stat.read_failed)
                begin
                    step_next = word.jmp;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, step and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/tgc_datapath.sv =====
// Datapath of the tilt gravity conditioner.
// Shared multiplier, rounding, clamp, stabilizer, filter and held state, driven by microcode.
// Depends on tgc_pkg.
module tgc_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  tgc_pkg::cfg_t             cfg,
    input  tgc_pkg::dp_ctrl_t         ctrl,
    input  logic signed [15:0]        accel_x,
    input  logic signed [15:0]        accel_y,
    input  logic signed [15:0]        accel_z,
    input  logic                      read_failed,
    output tgc_pkg::dp_stat_t         stat,
    output logic signed [15:0]        screen_grav_x,
    output logic signed [15:0]        screen_grav_y,
    output logic                      read_status
);

    // Sample and scratch registers
    logic signed [15:0]                   ax_reg;
    logic signed [15:0]                   ay_reg;
    logic signed [15:0]                   az_reg;
    logic                                 fail_reg;
    logic [31:0]                          acc_reg;
    logic                                 div_reg;
    logic signed [tgc_pkg::MUL_A_W-1:0]   sav_reg;
    logic signed [tgc_pkg::PROD_W-1:0]    prod_reg;
    logic signed [15:0]                   tx_reg;
    logic signed [15:0]                   ty_reg;

    // Filter and held state
    logic signed [15:0]                   filt_x_reg;
    logic signed [15:0]                   filt_y_reg;
    logic signed [15:0]                   held_x_reg;
    logic signed [15:0]                   held_y_reg;
    logic signed [15:0]                   filt_x_next;
    logic signed [15:0]                   filt_y_next;
    logic signed [15:0]                   held_x_next;
    logic signed [15:0]                   held_y_next;

    // Result registers
    logic signed [15:0]                   out_x_reg;
    logic signed [15:0]                   out_y_reg;
    logic                                 out_status_reg;

    logic signed [16:0]                   nay;
    logic signed [16:0]                   dx;
    logic signed [16:0]                   dy;
    logic [7:0]                           alpha_x;
    logic [7:0]                           alpha_y;
    logic signed [tgc_pkg::MUL_A_W-1:0]   mul_a;
    logic signed [tgc_pkg::MUL_B_W-1:0]   mul_b;
    logic signed [tgc_pkg::MUL_B_W-1:0]   coef;
    logic [tgc_pkg::PROD_W-1:0]           tgt_sum;
    logic signed [tgc_pkg::MUL_A_W-1:0]   tgt_rnd;
    logic signed [tgc_pkg::MUL_A_W-1:0]   lim;
    logic signed [tgc_pkg::MUL_A_W-1:0]   neg_lim;
    logic signed [15:0]                   tgt_clamped;
    logic signed [15:0]                   tgt_val;
    logic [24:0]                          flt_sum;
    logic signed [16:0]                   flt_step;
    logic signed [16:0]                   fx_sum;
    logic signed [16:0]                   fy_sum;
    logic signed [16:0]                   hx_diff;
    logic signed [16:0]                   hy_diff;
    logic                                 hold_x_upd;
    logic                                 hold_y_upd;
    logic [32:0]                          mag_sum;

    function automatic logic [16:0] abs17(input logic signed [16:0] v);
        return v[16] ? 17'(-v) : 17'(v);
    endfunction

    // Dead zone to zero, then snap to plus one, then to minus one
    function automatic logic signed [15:0] stabilize(
        input logic signed [15:0] v,
        input logic [11:0]        dz,
        input logic [11:0]        sb
    );
        logic signed [16:0] vw;
        logic signed [15:0] res;
        vw = 17'(v);
        priority if (abs17(vw) < {5'b0, dz})
            res = '0;
        else if (abs17(vw - tgc_pkg::ONE_Q14) < {5'b0, sb})
            res = 16'sd16384;
        else if (abs17(vw + tgc_pkg::ONE_Q14) < {5'b0, sb})
            res = -16'sd16384;
        else
            res = v;
        return res;
    endfunction

    // Filter steps and their weights
    assign nay     = 17'sd0 - 17'(ay_reg);
    assign dx      = 17'(tx_reg) - 17'(filt_x_reg);
    assign dy      = 17'(ty_reg) - 17'(filt_y_reg);
    assign alpha_x = (abs17(dx) >= {2'b0, cfg.fast_step}) ? cfg.motion_alpha : cfg.quiet_alpha;
    assign alpha_y = (abs17(dy) >= {2'b0, cfg.fast_step}) ? cfg.motion_alpha : cfg.quiet_alpha;
    assign coef    = div_reg ? $signed(tgc_pkg::INV_GRAVITY_Q16) : $signed(tgc_pkg::UNITY_COEF);

    // Select multiplier operands
    always_comb
    begin
        unique case (ctrl.a_sel)
            tgc_pkg::A_AX:      mul_a = tgc_pkg::MUL_A_W'(ax_reg);
            tgc_pkg::A_AY:      mul_a = tgc_pkg::MUL_A_W'(ay_reg);
            tgc_pkg::A_NAY:     mul_a = tgc_pkg::MUL_A_W'(nay);
            tgc_pkg::A_AZ:      mul_a = tgc_pkg::MUL_A_W'(az_reg);
            tgc_pkg::A_SAVED:   mul_a = sav_reg;
            tgc_pkg::A_DELTA_X: mul_a = tgc_pkg::MUL_A_W'(dx);
            tgc_pkg::A_DELTA_Y: mul_a = tgc_pkg::MUL_A_W'(dy);
            default:            mul_a = '0;
        endcase
        unique case (ctrl.b_sel)
            tgc_pkg::B_AX:      mul_b = tgc_pkg::MUL_B_W'(ax_reg);
            tgc_pkg::B_AY:      mul_b = tgc_pkg::MUL_B_W'(ay_reg);
            tgc_pkg::B_AZ:      mul_b = tgc_pkg::MUL_B_W'(az_reg);
            tgc_pkg::B_GAIN:    mul_b = tgc_pkg::MUL_B_W'($signed({1'b0, cfg.input_gain}));
            tgc_pkg::B_COEF:    mul_b = coef;
            tgc_pkg::B_ALPHA_X: mul_b = tgc_pkg::MUL_B_W'($signed({1'b0, alpha_x}));
            tgc_pkg::B_ALPHA_Y: mul_b = tgc_pkg::MUL_B_W'($signed({1'b0, alpha_y}));
            default:            mul_b = '0;
        endcase
    end

    // Round the scaled product by 2^18, ties away from zero, then clamp and stabilize
    assign tgt_sum = prod_reg + tgc_pkg::PROD_W'(131072) - tgc_pkg::PROD_W'(prod_reg[43]);
    assign tgt_rnd = $signed(tgt_sum[43:18]);
    assign lim     = $signed({11'b0, cfg.clamp_limit});
    assign neg_lim = -lim;

    always_comb
    begin
        priority if (tgt_rnd > lim)
            tgt_clamped = lim[15:0];
        else if (tgt_rnd < neg_lim)
            tgt_clamped = neg_lim[15:0];
        else
            tgt_clamped = tgt_rnd[15:0];
    end

    assign tgt_val = stabilize(tgt_clamped, cfg.dead_zone, cfg.snap_band);

    // Round the filter product by 256, ties away from zero
    assign flt_sum  = prod_reg[24:0] + 25'd128 - 25'(prod_reg[43]);
    assign flt_step = $signed(flt_sum[24:8]);
    assign fx_sum   = 17'(filt_x_reg) + flt_step;
    assign fy_sum   = 17'(filt_y_reg) + flt_step;

    // Hysteresis on the held outputs
    assign hx_diff    = 17'(filt_x_reg) - 17'(held_x_reg);
    assign hy_diff    = 17'(filt_y_reg) - 17'(held_y_reg);
    assign hold_x_upd = ctrl.hold_x && (abs17(hx_diff) >= {5'b0, cfg.out_hysteresis});
    assign hold_y_upd = ctrl.hold_y && (abs17(hy_diff) >= {5'b0, cfg.out_hysteresis});

    assign mag_sum = {1'b0, acc_reg} + {1'b0, prod_reg[31:0]};

    always_comb
    begin
        filt_x_next = (ctrl.act == tgc_pkg::ACT_FILT_X) ? fx_sum[15:0] : filt_x_reg;
        filt_y_next = (ctrl.act == tgc_pkg::ACT_FILT_Y) ? fy_sum[15:0] : filt_y_reg;
        held_x_next = hold_x_upd
                      ? stabilize(filt_x_reg, cfg.dead_zone, cfg.snap_band) : held_x_reg;
        held_y_next = hold_y_upd
                      ? stabilize(filt_y_reg, cfg.dead_zone, cfg.snap_band) : held_y_reg;
    end

    // Hold filter state, held outputs and the error flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_x_reg <= '0;
            filt_y_reg <= '0;
            held_x_reg <= '0;
            held_y_reg <= '0;
            fail_reg   <= 1'b0;
        end
        else
        begin
            filt_x_reg <= filt_x_next;
            filt_y_reg <= filt_y_next;
            held_x_reg <= held_x_next;
            held_y_reg <= held_y_next;
            if (ctrl.load)
                fail_reg <= read_failed;
        end
    end

    // Multiply every cycle, consume the previous product by the step's action
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (ctrl.load)
        begin
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            az_reg <= accel_z;
        end
        unique case (ctrl.act)
            tgc_pkg::ACT_ACC_LOAD: acc_reg <= prod_reg[31:0];
            tgc_pkg::ACT_ACC_ADD:  acc_reg <= acc_reg + prod_reg[31:0];
            tgc_pkg::ACT_DIV_SET:  div_reg <= (mag_sum > {1'b0, tgc_pkg::MAG_LIMIT_SQ});
            tgc_pkg::ACT_SAVE:     sav_reg <= prod_reg[tgc_pkg::MUL_A_W-1:0];
            tgc_pkg::ACT_TGT_X:    tx_reg  <= tgt_val;
            tgc_pkg::ACT_TGT_Y:    ty_reg  <= tgt_val;
            default:
            begin
            end
        endcase
        if (ctrl.emit)
        begin
            out_x_reg      <= held_x_reg;
            out_y_reg      <= held_y_reg;
            out_status_reg <= fail_reg;
        end
    end

    assign stat.read_failed = fail_reg;
    assign screen_grav_x    = out_x_reg;
    assign screen_grav_y    = out_y_reg;
    assign read_status      = out_status_reg;

endmodule

// ===== rtl/core/tilt_gravity_conditioner_core.sv =====
// Top level of the tilt gravity conditioner.
// Joins the register bank, the microcode sequencer and the datapath.
// Depends on tgc_pkg, tgc_cfg_regs, tgc_sequencer, tgc_datapath.
//
//  channel   direction  handshake               payload
//  s_axis    in         tvalid / tready         tdata: accel_x, accel_y, accel_z; tuser: read_failed
//  m_axis    out        tvalid / tready         tdata: screen_grav_x, screen_grav_y; tuser: read_status
//  cfg       in         cfg_we                  cfg_index, cfg_wdata
//
// An item runs through the accept cycle and twelve microcode steps, one pass of the
// shared multiplier per step. A failed read jumps from the first step straight to emit.
// Reset (rst_n low, asynchronous) clears the filter and held values and loads register defaults.
// One item is in work at a time; s_axis_tready is high whenever the sequencer is idle,
// even while a result still waits in the output register. The sequencer stalls at its emit
// step while that register is full and not being taken.
module tilt_gravity_conditioner_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [47:0]                     s_axis_tdata,   // accel_x, accel_y, accel_z
    input  logic                            s_axis_tuser,   // read_failed
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [31:0]                     m_axis_tdata,   // screen_grav_x, screen_grav_y
    output logic                            m_axis_tuser,   // read_status
    input  logic                            cfg_we,
    input  logic [tgc_pkg::CFG_ADDR_W-1:0]  cfg_index,
    input  logic [tgc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    tgc_pkg::cfg_t     cfg;
    tgc_pkg::dp_ctrl_t ctrl;
    tgc_pkg::dp_stat_t stat;
    logic signed [15:0] grav_x;
    logic signed [15:0] grav_y;

    tgc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tgc_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    tgc_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .ctrl          (ctrl),
        .accel_x       ($signed(s_axis_tdata[15:0])),
        .accel_y       ($signed(s_axis_tdata[31:16])),
        .accel_z       ($signed(s_axis_tdata[47:32])),
        .read_failed   (s_axis_tuser),
        .stat          (stat),
        .screen_grav_x (grav_x),
        .screen_grav_y (grav_y),
        .read_status   (m_axis_tuser)
    );

    assign m_axis_tdata = {grav_y, grav_x};

endmodule

// ===== rtl/core/tgc_checker.sv =====
// Port-level checks for the tilt gravity conditioner, bound to the top level.
// Tracks items in flight and the last delivered result.
// Depends on tilt_gravity_conditioner_core.
module tgc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [31:0]                     m_axis_tdata,
    input logic                            m_axis_tuser
);

    logic        in_acc;
    logic        out_acc;
    logic [1:0]  pend_reg;
    logic [1:0]  pend_next;
    logic [31:0] last_data_reg;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // Count items accepted but not yet delivered
    always_comb
    begin
        pend_next = pend_reg + 2'(in_acc) - 2'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            last_data_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (out_acc)
                last_data_reg <= m_axis_tdata;
        end
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // One item in work: input closes right after an accept
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_axis_tready)
        else $error("second item accepted while busy");

    // No result without an item, at most two in flight
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid || pend_reg != 2'd0) && pend_reg != 2'd3)
        else $error("result count does not match items");

    // A read error repeats the last delivered gravity
    a_error_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == last_data_reg)
        else $error("read error changed the held output");

endmodule

bind tilt_gravity_conditioner_core tgc_checker u_tgc_checker (.*);
